// ===== sv/utf8sd_pkg.sv =====
// Shared types, constants and helper functions for the UTF-8 stream decoder.
// Used by every module of the block; depends on nothing else.
package utf8sd_pkg;

    localparam int INDEX_BITS     = 32;
    localparam int ERR_INDEX_BITS = 32;
    localparam int CODE_BITS      = 21;
    localparam int FIFO_DEPTH     = 4;
    localparam int FIFO_PTR_BITS  = $clog2(FIFO_DEPTH);

    localparam logic [2:0] ERR_NONE     = 3'd0;
    localparam logic [2:0] ERR_END      = 3'd1;
    localparam logic [2:0] ERR_BROKEN   = 3'd2;
    localparam logic [2:0] ERR_OVERLONG = 3'd3;
    localparam logic [2:0] ERR_RANGE    = 3'd4;
    localparam logic [2:0] ERR_BAD_LEAD = 3'd5;

    localparam logic [1:0] LEAD_ASCII = 2'd0;
    localparam logic [1:0] LEAD_MULTI = 2'd1;
    localparam logic [1:0] LEAD_BAD   = 2'd2;

    localparam logic [CODE_BITS-1:0] REPLACEMENT  = 21'h00FFFD;
    localparam logic [CODE_BITS-1:0] MIN_TWO      = 21'h000080;
    localparam logic [CODE_BITS-1:0] MIN_THREE    = 21'h000800;
    localparam logic [CODE_BITS-1:0] MIN_FOUR     = 21'h010000;
    localparam logic [CODE_BITS-1:0] MAX_CODE     = 21'h10FFFF;

    typedef struct packed {
        logic [CODE_BITS-1:0]      code_value;
        logic [2:0]                error_code;
        logic [ERR_INDEX_BITS-1:0] error_index;
        logic                      string_end;
        logic                      run_last;
    } res_t;

    typedef struct packed {
        res_t first;
        res_t second;
        logic two;
    } entry_t;

    typedef struct packed {
        logic empty;
        logic full;
    } fifo_status_t;

    typedef struct packed {
        logic [1:0]           kind;
        logic [1:0]           len;
        logic [CODE_BITS-1:0] part;
    } lead_t;

    function automatic lead_t lead_decode(input logic [7:0] b);
        lead_t l;
        l.kind = LEAD_BAD;
        l.len  = 2'd0;
        l.part = '0;
        if (b[7] == 1'b0) begin
            l.kind = LEAD_ASCII;
        end else if (b[7:5] == 3'b110) begin
            l.kind = LEAD_MULTI;
            l.len  = 2'd1;
            l.part = {10'b0, b[4:0], 6'b0};
        end else if (b[7:4] == 4'b1110) begin
            l.kind = LEAD_MULTI;
            l.len  = 2'd2;
            l.part = {5'b0, b[3:0], 12'b0};
        end else if (b[7:3] == 5'b11110) begin
            l.kind = LEAD_MULTI;
            l.len  = 2'd3;
            l.part = {b[2:0], 18'b0};
        end
        return l;
    endfunction

    function automatic res_t make_result(input logic [CODE_BITS-1:0]  value,
                                         input logic [2:0]            code,
                                         input logic [INDEX_BITS-1:0] where);
        res_t r;
        r.string_end = 1'b0;
        r.run_last   = 1'b0;
        r.error_code = code;
        if (code != ERR_NONE) begin
            r.code_value  = REPLACEMENT;
            r.error_index = ERR_INDEX_BITS'(where);
        end else begin
            r.code_value  = value;
            r.error_index = '0;
        end
        return r;
    endfunction

endpackage

// ===== sv/utf8_stream_decoder_unit.sv =====
// Top level of the UTF-8 stream decoder: front end, bundle queue and back end.
// Depends on utf8sd_pkg, utf8sd_front, utf8sd_fifo and utf8sd_back.
//
// Channel   Handshake                    Beat fields
// input     byte_valid / byte_stall      data_byte, string_last
// result    result_valid / result_stall  code_value, error_code, error_index,
//                                        string_end, run_last
//
// A byte is taken every cycle while the four-entry queue has room; the front end
// settles its whole state update in that cycle.
// A byte that yields two results is unpacked by the back end into two beats, one
// after the other, before its queue entry is popped.
// The first result of a byte is written into a queue slot and then loaded into
// the back end's output register, where result_stall holds it.
// Reset clears the sequence state, the byte index, the queue and the output valid.
// byte_stall rises only when the queue is full; result_stall holds the output beat.
module utf8_stream_decoder_unit
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        byte_valid,
    output logic        byte_stall,
    input  logic [7:0]  data_byte,
    input  logic        string_last,
    output logic        result_valid,
    input  logic        result_stall,
    output logic [20:0] code_value,
    output logic [2:0]  error_code,
    output logic [31:0] error_index,
    output logic        string_end,
    output logic        run_last
);

    utf8sd_pkg::fifo_status_t status;
    utf8sd_pkg::entry_t       push_entry;
    utf8sd_pkg::entry_t       head;
    utf8sd_pkg::res_t         result;
    logic                     push;
    logic                     pop;

    utf8sd_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_valid  (byte_valid),
        .byte_stall  (byte_stall),
        .data_byte   (data_byte),
        .string_last (string_last),
        .status      (status),
        .push        (push),
        .push_entry  (push_entry)
    );

    utf8sd_fifo u_fifo
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .status     (status)
    );

    utf8sd_back u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .status       (status),
        .pop          (pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    assign code_value  = result.code_value;
    assign error_code  = result.error_code;
    assign error_index = result.error_index;
    assign string_end  = result.string_end;
    assign run_last    = result.run_last;

endmodule

// ===== sv/utf8sd_front.sv =====
// Front end of the UTF-8 stream decoder: accepts bytes, tracks the open sequence
// and bundles the one or two results that a byte may yield for the queue.
// Depends on utf8sd_pkg.
module utf8sd_front
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  byte_valid,
    output logic                  byte_stall,
    input  logic [7:0]            data_byte,
    input  logic                  string_last,
    input  utf8sd_pkg::fifo_status_t status,
    output logic                  push,
    output utf8sd_pkg::entry_t    push_entry
);

    logic [1:0]                             pend_reg, pend_next;
    logic [1:0]                             seq_reg, seq_next;
    logic [utf8sd_pkg::CODE_BITS-1:0]       part_reg, part_next;
    logic [utf8sd_pkg::INDEX_BITS-1:0]      idx_reg, idx_next;

    utf8sd_pkg::lead_t                      lead;
    logic                                   is_cont;
    logic                                   accept;
    logic                                   run_lead;
    logic [utf8sd_pkg::CODE_BITS-1:0]       cont_bits;
    logic [utf8sd_pkg::CODE_BITS-1:0]       merged;
    logic                                   a_valid, b_valid;
    logic [utf8sd_pkg::CODE_BITS-1:0]       a_value, b_value;
    logic [2:0]                             a_code, b_code;
    logic [utf8sd_pkg::INDEX_BITS-1:0]      a_where;
    utf8sd_pkg::res_t                       res_a, res_b;
    utf8sd_pkg::entry_t                     entry;

    assign byte_stall = status.full;
    assign accept     = byte_valid && !byte_stall;
    assign push       = accept && (a_valid || b_valid);
    assign push_entry = entry;

    always_comb
    begin
        lead    = utf8sd_pkg::lead_decode(data_byte);
        is_cont = (data_byte[7:6] == 2'b10);
        case (pend_reg)
            2'd1:    cont_bits = {15'b0, data_byte[5:0]};
            2'd2:    cont_bits = {9'b0, data_byte[5:0], 6'b0};
            2'd3:    cont_bits = {3'b0, data_byte[5:0], 12'b0};
            default: cont_bits = '0;
        endcase
        merged = part_reg | cont_bits;

        pend_next = pend_reg;
        seq_next  = seq_reg;
        part_next = part_reg;
        run_lead  = 1'b0;
        a_valid   = 1'b0;
        a_value   = merged;
        a_code    = utf8sd_pkg::ERR_NONE;
        a_where   = idx_reg;
        b_valid   = 1'b0;
        b_value   = {13'b0, data_byte};
        b_code    = utf8sd_pkg::ERR_NONE;

        if (pend_reg != 2'd0) begin
            if (is_cont) begin
                pend_next = pend_reg - 2'd1;
                part_next = merged;
                if (pend_reg == 2'd1) begin
                    a_valid = 1'b1;
                    case (seq_reg)
                        2'd1:
                        begin
                            if (merged < utf8sd_pkg::MIN_TWO)
                                a_code = utf8sd_pkg::ERR_OVERLONG;
                        end
                        2'd2:
                        begin
                            if (merged < utf8sd_pkg::MIN_THREE)
                                a_code = utf8sd_pkg::ERR_OVERLONG;
                        end
                        default:
                        begin
                            if (merged < utf8sd_pkg::MIN_FOUR)
                                a_code = utf8sd_pkg::ERR_OVERLONG;
                            else if (merged > utf8sd_pkg::MAX_CODE)
                                a_code = utf8sd_pkg::ERR_RANGE;
                        end
                    endcase
                    pend_next = 2'd0;
                    seq_next  = 2'd0;
                    part_next = '0;
                end else if (string_last) begin
                    a_valid = 1'b1;
                    a_code  = utf8sd_pkg::ERR_END;
                end
            end else begin
                a_valid   = 1'b1;
                a_code    = utf8sd_pkg::ERR_BROKEN;
                a_where   = idx_reg - 1'b1;
                pend_next = 2'd0;
                seq_next  = 2'd0;
                part_next = '0;
                run_lead  = 1'b1;
            end
        end else begin
            run_lead = 1'b1;
        end

        if (run_lead) begin
            case (lead.kind)
                utf8sd_pkg::LEAD_ASCII:
                begin
                    b_valid = 1'b1;
                end
                utf8sd_pkg::LEAD_MULTI:
                begin
                    pend_next = lead.len;
                    seq_next  = lead.len;
                    part_next = lead.part;
                    if (string_last) begin
                        b_valid = 1'b1;
                        b_code  = utf8sd_pkg::ERR_END;
                    end
                end
                default:
                begin
                    b_valid = 1'b1;
                    b_code  = utf8sd_pkg::ERR_BAD_LEAD;
                end
            endcase
        end

        if (string_last) begin
            pend_next = 2'd0;
            seq_next  = 2'd0;
            part_next = '0;
            idx_next  = '0;
        end else begin
            idx_next = idx_reg + 1'b1;
        end

        res_a = utf8sd_pkg::make_result(a_value, a_code, a_where);
        res_b = utf8sd_pkg::make_result(b_value, b_code, idx_reg);

        if (a_valid) begin
            entry.first  = res_a;
            entry.second = res_b;
            entry.two    = b_valid;
        end else begin
            entry.first  = res_b;
            entry.second = res_b;
            entry.two    = 1'b0;
        end
        if (entry.two) begin
            entry.second.run_last   = 1'b1;
            entry.second.string_end = string_last;
        end else begin
            entry.first.run_last   = 1'b1;
            entry.first.string_end = string_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            pend_reg <= 2'd0;
            seq_reg  <= 2'd0;
            part_reg <= '0;
            idx_reg  <= '0;
        end else if (accept) begin
            pend_reg <= pend_next;
            seq_reg  <= seq_next;
            part_reg <= part_next;
            idx_reg  <= idx_next;
        end
    end

endmodule

// ===== sv/utf8sd_fifo.sv =====
// Short queue of result bundles between the front and back ends of the decoder.
// Depends on utf8sd_pkg.
module utf8sd_fifo
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     push,
    input  utf8sd_pkg::entry_t       push_entry,
    input  logic                     pop,
    output utf8sd_pkg::entry_t       head,
    output utf8sd_pkg::fifo_status_t status
);

    utf8sd_pkg::entry_t                     slots_reg [utf8sd_pkg::FIFO_DEPTH];
    logic [utf8sd_pkg::FIFO_PTR_BITS-1:0]   wr_reg, wr_next;
    logic [utf8sd_pkg::FIFO_PTR_BITS-1:0]   rd_reg, rd_next;
    logic [utf8sd_pkg::FIFO_PTR_BITS:0]     count_reg, count_next;

    assign head         = slots_reg[rd_reg];
    assign status.empty = (count_reg == '0);
    assign status.full  = (count_reg == (utf8sd_pkg::FIFO_PTR_BITS+1)'(utf8sd_pkg::FIFO_DEPTH));

    always_comb
    begin
        wr_next    = push ? wr_reg + 1'b1 : wr_reg;
        rd_next    = pop ? rd_reg + 1'b1 : rd_reg;
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slots_reg[wr_reg] <= push_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end else begin
            wr_reg    <= wr_next;
            rd_reg    <= rd_next;
            count_reg <= count_next;
        end
    end

endmodule

// ===== sv/utf8sd_back.sv =====
// Back end of the UTF-8 stream decoder: unpacks each queued bundle into one or
// two result beats through an output register. Depends on utf8sd_pkg.
module utf8sd_back
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  utf8sd_pkg::entry_t       head,
    input  utf8sd_pkg::fifo_status_t status,
    output logic                     pop,
    output logic                     result_valid,
    input  logic                     result_stall,
    output utf8sd_pkg::res_t         result
);

    logic             valid_reg, valid_next;
    logic             half_reg, half_next;
    utf8sd_pkg::res_t res_reg;
    logic             load;
    utf8sd_pkg::res_t pick;

    assign result_valid = valid_reg;
    assign result       = res_reg;

    always_comb
    begin
        load = !status.empty && (!valid_reg || !result_stall);
        pick = half_reg ? head.second : head.first;
        pop  = load && (half_reg || !head.two);

        half_next  = half_reg;
        valid_next = valid_reg;
        if (load) begin
            half_next  = !half_reg && head.two;
            valid_next = 1'b1;
        end else if (!result_stall) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            res_reg <= pick;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
            half_reg  <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            half_reg  <= half_next;
        end
    end

endmodule
